[sv/nnps_pkg.sv]
// Shared types, constants and helpers for the nearest-neighbor pixel scatter unit.
package nnps_pkg;

  localparam int unsigned CFG_DIM_W   = 13;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned INDEX_W     = 24;
  localparam int unsigned DEF_MAX_DIM = 4096;
  localparam int unsigned S_DATA_W    = 4 * PIX_W;
  localparam int unsigned M_DATA_W    = INDEX_W + 4 * PIX_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_HAS_ALPHA  = 3'd4,
    REG_POW2_MODE  = 3'd5
  } cfg_reg_e;

  // Controller -> datapath
  typedef struct packed {
    logic load_dims;
    logic div_step;
    logic accept;
    logic row_base;
  } nnps_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic cfg_wr;
    logic col_last;
    logic out_busy;
  } nnps_sts_t;

  // Coordinate width: enough for the clamped size, never above the register width.
  function automatic int unsigned dim_width(input int unsigned max_dim);
    int unsigned w;
    w = $clog2(max_dim + 1);
    return (w < CFG_DIM_W) ? w : CFG_DIM_W;
  endfunction

  // Largest power of two not above v (v >= 1).
  function automatic logic [CFG_DIM_W-1:0] floor_pow2(input logic [CFG_DIM_W-1:0] v);
    logic [CFG_DIM_W-1:0] p;
    p = CFG_DIM_W'(1);
    for (int i = 0; i < CFG_DIM_W; i++) begin
      if (v[i]) begin
        p = CFG_DIM_W'(1) << i;
      end
    end
    return p;
  endfunction

endpackage

[sv/nnps_ctrl.sv]
// Sequencer for the nearest-neighbor pixel scatter unit: step setup, pixel accept, row base.
module nnps_ctrl
  import nnps_pkg::*;
#(
  parameter int unsigned MAX_DIM = DEF_MAX_DIM
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  nnps_sts_t sts_i,
  input  logic      step_row_i,
  output nnps_cmd_t cmd_o,
  output logic      s_axis_tready
);

  localparam int unsigned DIM_W = dim_width(MAX_DIM);
  localparam int unsigned CNT_W = (DIM_W > 1) ? $clog2(DIM_W) : 1;

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_IDLE = 4'b0100,
    ST_ROWB = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             take;

  assign take          = (state_q == ST_IDLE) && !sts_i.out_busy && !sts_i.cfg_wr;
  assign s_axis_tready = take;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    cmd_o          = '0;
    unique case (state_q)
      ST_LOAD: begin
        cmd_o.load_dims = 1'b1;
        cnt_d           = CNT_W'(DIM_W - 1);
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // last pixel of a source row taken: rebuild the row base next
        if (step_row_i) begin
          state_d = ST_ROWB;
        end
      end
      ST_ROWB: begin
        cmd_o.row_base = 1'b1;
        state_d        = ST_IDLE;
      end
      default: state_d = ST_LOAD;
    endcase
    // datapath gates accept with the stream valid
    if (take) begin
      cmd_o.accept = 1'b1;
    end
    // any register write restarts the frame and redoes the step setup
    if (sts_i.cfg_wr) begin
      state_d = ST_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // a column wrap rebuilds the row base in ST_ROWB
  logic unused_col_last;
  assign unused_col_last = sts_i.col_last;

endmodule

[sv/nnps_dp.sv]
// Datapath: config registers, step dividers, coordinate stepping and output register.
module nnps_dp
  import nnps_pkg::*;
#(
  parameter int unsigned MAX_DIM = DEF_MAX_DIM
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nnps_cmd_t            cmd_i,
  output nnps_sts_t            sts_o,
  output logic                 step_row_o,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DIM_W-1:0] cfg_data_i,
  input  logic                 s_axis_tvalid,
  input  logic [S_DATA_W-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_DATA_W-1:0]  m_axis_tdata,
  output logic                 m_axis_tlast
);

  localparam int unsigned DIM_W = dim_width(MAX_DIM);

  // configuration
  logic [CFG_DIM_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic                 has_alpha_q, pow2_q;
  logic                 cfg_wr;

  // effective sizes, captured at setup
  logic [DIM_W-1:0] sw_q, sh_q, dw_q, dh_q;
  logic [DIM_W-1:0] sw_e, sh_e, dw_e, dh_e;

  // per-axis divider: quotient and remainder of dst/src
  logic [DIM_W-1:0] cq_q, cr_q, rq_q, rr_q;

  // frame position
  logic [DIM_W-1:0]   col_q, col_d, row_q, row_d;
  logic [DIM_W-1:0]   dcol_q, dcol_d, crem_q, crem_d;
  logic [DIM_W-1:0]   drow_q, drow_d, rrem_q, rrem_d;
  logic [INDEX_W-1:0] rbase_q;

  // output register
  logic                out_valid_q;
  logic [M_DATA_W-1:0] out_data_q;
  logic                out_last_q;

  logic accept;
  logic col_last, row_last;
  logic [DIM_W:0] csum, rsum;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  assign cfg_wr = cfg_valid_i && (cfg_index_i <= REG_POW2_MODE);

  always_comb begin
    sw_e = clamp_dim(src_w_q);
    sh_e = clamp_dim(src_h_q);
    if (pow2_q) begin
      dw_e = DIM_W'(floor_pow2(CFG_DIM_W'(sw_e)));
      dh_e = DIM_W'(floor_pow2(CFG_DIM_W'(sh_e)));
    end else begin
      dw_e = clamp_dim(dst_w_q);
      dh_e = clamp_dim(dst_h_q);
    end
  end

  // restoring division step: quotient bits shift in where dividend bits leave
  function automatic logic [2*DIM_W-1:0] div_step(input logic [DIM_W-1:0] rem,
                                                  input logic [DIM_W-1:0] quo,
                                                  input logic [DIM_W-1:0] dvs);
    logic [DIM_W:0]   trial;
    logic [DIM_W-1:0] r;
    logic             b;
    trial = {rem, quo[DIM_W-1]};
    b     = (trial >= {1'b0, dvs});
    r     = b ? DIM_W'(trial - {1'b0, dvs}) : DIM_W'(trial);
    return {r, quo[DIM_W-2:0], b};
  endfunction

  assign accept   = cmd_i.accept && s_axis_tvalid;
  assign col_last = (col_q == sw_q - DIM_W'(1));
  assign row_last = (row_q == sh_q - DIM_W'(1));
  assign csum     = {1'b0, crem_q} + {1'b0, cr_q};
  assign rsum     = {1'b0, rrem_q} + {1'b0, rr_q};

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    dcol_d = dcol_q;
    crem_d = crem_q;
    drow_d = drow_q;
    rrem_d = rrem_q;
    if (accept) begin
      if (col_last) begin
        col_d  = '0;
        dcol_d = '0;
        crem_d = '0;
        if (row_last) begin
          row_d  = '0;
          drow_d = '0;
          rrem_d = '0;
        end else begin
          row_d = row_q + DIM_W'(1);
          if (rsum >= {1'b0, sh_q}) begin
            rrem_d = DIM_W'(rsum - {1'b0, sh_q});
            drow_d = drow_q + rq_q + DIM_W'(1);
          end else begin
            rrem_d = DIM_W'(rsum);
            drow_d = drow_q + rq_q;
          end
        end
      end else begin
        col_d = col_q + DIM_W'(1);
        if (csum >= {1'b0, sw_q}) begin
          crem_d = DIM_W'(csum - {1'b0, sw_q});
          dcol_d = dcol_q + cq_q + DIM_W'(1);
        end else begin
          crem_d = DIM_W'(csum);
          dcol_d = dcol_q + cq_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q     <= CFG_DIM_W'(1);
      src_h_q     <= CFG_DIM_W'(1);
      dst_w_q     <= CFG_DIM_W'(1);
      dst_h_q     <= CFG_DIM_W'(1);
      has_alpha_q <= 1'b0;
      pow2_q      <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      dcol_q      <= '0;
      crem_q      <= '0;
      drow_q      <= '0;
      rrem_q      <= '0;
      rbase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index_i)
          REG_SRC_WIDTH:  src_w_q     <= cfg_data_i;
          REG_SRC_HEIGHT: src_h_q     <= cfg_data_i;
          REG_DST_WIDTH:  dst_w_q     <= cfg_data_i;
          REG_DST_HEIGHT: dst_h_q     <= cfg_data_i;
          REG_HAS_ALPHA:  has_alpha_q <= cfg_data_i[0];
          REG_POW2_MODE:  pow2_q      <= cfg_data_i[0];
          default:        has_alpha_q <= has_alpha_q;
        endcase
        col_q   <= '0;
        row_q   <= '0;
        dcol_q  <= '0;
        crem_q  <= '0;
        drow_q  <= '0;
        rrem_q  <= '0;
        rbase_q <= '0;
      end else begin
        col_q  <= col_d;
        row_q  <= row_d;
        dcol_q <= dcol_d;
        crem_q <= crem_d;
        drow_q <= drow_d;
        rrem_q <= rrem_d;
        if (cmd_i.row_base) begin
          rbase_q <= INDEX_W'(drow_q) * INDEX_W'(dw_q);
        end
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_dims) begin
      sw_q <= sw_e;
      sh_q <= sh_e;
      dw_q <= dw_e;
      dh_q <= dh_e;
      cr_q <= '0;
      cq_q <= dw_e;
      rr_q <= '0;
      rq_q <= dh_e;
    end else if (cmd_i.div_step) begin
      {cr_q, cq_q} <= div_step(cr_q, cq_q, sw_q);
      {rr_q, rq_q} <= div_step(rr_q, rq_q, sh_q);
    end
    if (accept) begin
      out_data_q <= {has_alpha_q ? s_axis_tdata[4*PIX_W-1:3*PIX_W] : PIX_W'(0),
                     s_axis_tdata[3*PIX_W-1:0],
                     rbase_q + INDEX_W'(dcol_q)};
      out_last_q <= col_last && row_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  assign step_row_o     = accept && col_last;
  assign sts_o.cfg_wr   = cfg_wr;
  assign sts_o.col_last = col_last;
  assign sts_o.out_busy = out_valid_q && !m_axis_tready;

  // dh only seeds the row divider
  logic unused_dh;
  assign unused_dh = ^dh_q;

endmodule

[sv/nearest_neighbor_pixel_scatter_unit.sv]
// Nearest-neighbor pixel scatter unit: maps each source pixel to its destination index.
//
// Source pixels come in row-major order, one RGBA beat each, and each leaves as one beat
// carrying floor(dw*col/sw) + floor(dh*row/sh)*dw and the channels (alpha zeroed when
// alpha is off); tlast marks the last pixel of the frame. Coordinates are stepped by
// adding a precomputed quotient and remainder per pixel, and after the last pixel of
// each source row the unit takes no pixel while the row base dest_row*dw goes
// through the multiplier. After reset and after every register write the unit divides
// dst by src sizes with a restoring divider, one bit a cycle, before it takes the first
// pixel; any write restarts the frame.
module nearest_neighbor_pixel_scatter_unit
  import nnps_pkg::*;
#(
  parameter int unsigned MAX_DIM = DEF_MAX_DIM
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write: index 0 src_width, 1 src_height, 2 dst_width, 3 dst_height,
  // 4 has_alpha, 5 pow2_mode
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DIM_W-1:0] cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_DATA_W-1:0]  s_axis_tdata,   // red, green, blue, alpha
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_DATA_W-1:0]  m_axis_tdata,   // dest_index, out_red, out_green,
                                               // out_blue, out_alpha
  output logic                 m_axis_tlast    // frame_end
);

  nnps_cmd_t cmd;
  nnps_sts_t sts;
  logic      step_row;

  assign cfg_ready_o = 1'b1;

  nnps_ctrl #(
    .MAX_DIM(MAX_DIM)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sts_i        (sts),
    .step_row_i   (step_row),
    .cmd_o        (cmd),
    .s_axis_tready(s_axis_tready)
  );

  nnps_dp #(
    .MAX_DIM(MAX_DIM)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .step_row_o   (step_row),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule
